// File: hw/rtl/zb32_pkg.sv
// Shared types and the z-base-32 alphabet tables for the z-base-32 decoder.
package zb32_pkg;

   localparam int unsigned SymbolWidth = 8;
   localparam int unsigned CodeWidth   = 5;
   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned AlphaSize   = 1 << CodeWidth;
   localparam int unsigned PendWidth   = ByteWidth - 1;
   localparam int unsigned CountWidth  = 3;

   // Alphabet in code order, lower case and upper case spellings.
   localparam logic [SymbolWidth-1:0] ZB_LOWER [AlphaSize] = '{
      8'h79, 8'h62, 8'h6E, 8'h64, 8'h72, 8'h66, 8'h67, 8'h38,
      8'h65, 8'h6A, 8'h6B, 8'h6D, 8'h63, 8'h70, 8'h71, 8'h78,
      8'h6F, 8'h74, 8'h31, 8'h75, 8'h77, 8'h69, 8'h73, 8'h7A,
      8'h61, 8'h33, 8'h34, 8'h35, 8'h68, 8'h37, 8'h36, 8'h39
   };
   localparam logic [SymbolWidth-1:0] ZB_UPPER [AlphaSize] = '{
      8'h59, 8'h42, 8'h4E, 8'h44, 8'h52, 8'h46, 8'h47, 8'h38,
      8'h45, 8'h4A, 8'h4B, 8'h4D, 8'h43, 8'h50, 8'h51, 8'h58,
      8'h4F, 8'h54, 8'h31, 8'h55, 8'h57, 8'h49, 8'h53, 8'h5A,
      8'h41, 8'h33, 8'h34, 8'h35, 8'h48, 8'h37, 8'h36, 8'h39
   };

   // Result of mapping one character.
   typedef struct packed {
      logic                 hit;
      logic [CodeWidth-1:0] code;
   } symbol_map_type;

endpackage

// File: hw/rtl/zb32_symbol_map.sv
// Maps one character to its 5-bit z-base-32 code, flagging non-alphabet characters.
module zb32_symbol_map (
   input  logic [zb32_pkg::SymbolWidth-1:0] symbol,
   output zb32_pkg::symbol_map_type         map
);
   import zb32_pkg::*;

   // Each table entry is compared on its own; at most one entry matches.
   always_comb begin
      map = '0;
      for (int k = 0; k < AlphaSize; k++) begin
         if (symbol == ZB_LOWER[k] || symbol == ZB_UPPER[k]) begin
            map.hit  = 1'b1;
            map.code = CodeWidth'(k);
         end
      end
   end

endmodule

// File: hw/rtl/zbase32_decoder_core.sv
// Top level of the z-base-32 stream decoder: input register, bit accumulator, result register.
// A character accepted into the input register is decoded there; any result word it yields
// is registered in the result register once that register is free, and is then offered on
// the result channel.
// Throughput: one input word per cycle, limited only by the result side taking its words.
// Reset (synchronous, active high) empties both registers and clears the pending bits.
module zbase32_decoder_core (
   input  logic                             clock,
   input  logic                             reset,
   // Input channel.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [zb32_pkg::SymbolWidth-1:0] req_tdata,   // [7:0] symbol
   // Result channel.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [zb32_pkg::ByteWidth-1:0]   rsp_tdata,   // [7:0] data_byte
   output logic                             rsp_tuser,   // [0] byte_valid
   output logic                             rsp_tlast    // stream_end
);
   import zb32_pkg::*;

   localparam int unsigned AccWidth   = PendWidth + CodeWidth;
   localparam int unsigned TotalWidth = CountWidth + 1;

   // Input register.
   logic                   in_valid_ff, in_valid_in;
   logic [SymbolWidth-1:0] in_symbol_ff, in_symbol_in;

   // Bit accumulator: pending bits right aligned, and how many there are.
   logic [PendWidth-1:0]  bit_buffer_ff, bit_buffer_in;
   logic [CountWidth-1:0] bit_count_ff, bit_count_in;

   // Result register.
   logic                 out_valid_ff, out_valid_in;
   logic [ByteWidth-1:0] out_byte_ff, out_byte_in;
   logic                 out_flag_ff, out_flag_in;
   logic                 out_end_ff, out_end_in;

   symbol_map_type       map;
   logic [AccWidth-1:0]  acc;
   logic [TotalWidth-1:0] total;
   logic [TotalWidth-1:0] rem;
   logic                 byte_done;
   logic                 makes_word;
   logic                 out_free;
   logic                 advance;

   zb32_symbol_map u_map (
      .symbol (in_symbol_ff),
      .map    (map)
   );

   // A registered character yields a result word when it ends the stream or completes a byte.
   // It leaves the input register when it yields nothing, or when the result register is free.
   // Non-alphabet characters also clear the pending bits, starting a fresh stream.
   assign acc        = {bit_buffer_ff, map.code};
   assign total      = TotalWidth'(bit_count_ff) + TotalWidth'(CodeWidth);
   assign byte_done  = total >= TotalWidth'(ByteWidth);
   assign rem        = total - TotalWidth'(ByteWidth);
   assign makes_word = !map.hit || byte_done;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && (!makes_word || out_free);

   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_symbol_in = in_symbol_ff;
      if (req_tready) begin
         in_valid_in  = req_tvalid;
         in_symbol_in = req_tdata;
      end
   end

   always_comb begin
      bit_buffer_in = bit_buffer_ff;
      bit_count_in  = bit_count_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_byte_in   = out_byte_ff;
      out_flag_in   = out_flag_ff;
      out_end_in    = out_end_ff;
      if (advance) begin
         if (!map.hit) begin
            // End of stream: drop the pending bits and report the end marker.
            bit_buffer_in = '0;
            bit_count_in  = '0;
            out_valid_in  = 1'b1;
            out_byte_in   = '0;
            out_flag_in   = 1'b0;
            out_end_in    = 1'b1;
         end else if (byte_done) begin
            // Top eight of the gathered bits form the byte; the rest stay pending.
            out_byte_in   = ByteWidth'(acc >> rem);
            out_valid_in  = 1'b1;
            out_flag_in   = 1'b1;
            out_end_in    = 1'b0;
            bit_buffer_in = PendWidth'(acc & ((AccWidth'(1) << rem) - AccWidth'(1)));
            bit_count_in  = CountWidth'(rem);
         end else begin
            bit_buffer_in = PendWidth'(acc);
            bit_count_in  = CountWidth'(total);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         bit_buffer_ff <= '0;
         bit_count_ff  <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         bit_buffer_ff <= bit_buffer_in;
         bit_count_ff  <= bit_count_in;
      end
   end

   always_ff @(posedge clock) begin
      in_symbol_ff <= in_symbol_in;
      out_byte_ff  <= out_byte_in;
      out_flag_ff  <= out_flag_in;
      out_end_ff   <= out_end_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_flag_ff;
   assign rsp_tlast  = out_end_ff;

endmodule

// File: sim/zb32_check_pkg.sv
// Expected-word type and the decoded-byte predictor used by the z-base-32 decoder bench.
`timescale 1ns / 1ps
package zb32_check_pkg;

   import zb32_pkg::*;

   // One result word as the decoder should present it.
   typedef struct packed {
      logic [ByteWidth-1:0] data_byte;
      logic                 byte_valid;
      logic                 stream_end;
   } decoded_word_type;

   class zb32_byte_predictor;

      logic [PendWidth-1:0]  pend_bits;
      logic [CountWidth-1:0] pend_count;
      decoded_word_type      expected_words[$];
      int unsigned           mismatches;

      function new();
         restart();
         mismatches = 0;
      endfunction

      function void restart();
         pend_bits  = '0;
         pend_count = '0;
      endfunction

      // Returns 1 and the 5-bit code when the character is in the alphabet, either case.
      function bit lookup(input logic [SymbolWidth-1:0] ch, output logic [CodeWidth-1:0] code);
         code = '0;
         for (int k = 0; k < AlphaSize; k++) begin
            if (ZB_LOWER[k] == ch || ZB_UPPER[k] == ch) begin
               code = k[CodeWidth-1:0];
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      // Advances the pending bits by one accepted character and queues any word it causes.
      function void take_symbol(input logic [SymbolWidth-1:0] ch);
         logic [CodeWidth-1:0]           code;
         logic [PendWidth+CodeWidth-1:0] acc;
         logic [PendWidth+CodeWidth-1:0] shifted;
         logic [3:0]                     total;
         logic [3:0]                     rem;
         decoded_word_type               word;
         if (!lookup(ch, code)) begin
            word = '{data_byte: '0, byte_valid: 1'b0, stream_end: 1'b1};
            expected_words.push_back(word);
            restart();
            return;
         end
         acc   = {pend_bits, code};
         total = {1'b0, pend_count} + 4'd5;
         if (total < 4'd8) begin
            pend_bits  = acc[PendWidth-1:0];
            pend_count = total[CountWidth-1:0];
         end else begin
            rem     = total - 4'd8;
            shifted = acc >> rem;
            word    = '{data_byte: shifted[ByteWidth-1:0], byte_valid: 1'b1, stream_end: 1'b0};
            expected_words.push_back(word);
            acc        = acc & ((12'd1 << rem) - 12'd1);
            pend_bits  = acc[PendWidth-1:0];
            pend_count = rem[CountWidth-1:0];
         end
      endfunction

      task report_mismatch(input string what);
         $display("[%0t] MISMATCH: %s", $time, what);
         mismatches++;
      endtask

      // Compares one accepted result word against the oldest expectation.
      task check_word(input logic [ByteWidth-1:0] data_byte, input logic byte_valid,
                      input logic stream_end);
         decoded_word_type want;
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("result word %h/%b/%b with nothing expected",
                                      data_byte, byte_valid, stream_end));
            return;
         end
         want = expected_words.pop_front();
         if (data_byte !== want.data_byte)
            report_mismatch($sformatf("data_byte %h, expected %h", data_byte, want.data_byte));
         if (byte_valid !== want.byte_valid)
            report_mismatch($sformatf("byte_valid %b, expected %b", byte_valid,
                                      want.byte_valid));
         if (stream_end !== want.stream_end)
            report_mismatch($sformatf("stream_end %b, expected %b", stream_end,
                                      want.stream_end));
      endtask

      task check_drained();
         if (expected_words.size() != 0)
            report_mismatch($sformatf("%0d expected words never arrived",
                                      expected_words.size()));
      endtask

   endclass

endpackage

// File: sim/tb_zbase32_decoder_core.sv
// Self-checking bench for the z-base-32 stream decoder core.
`timescale 1ns / 1ps
module tb_zbase32_decoder_core;

   import zb32_pkg::*;
   import zb32_check_pkg::*;

   // Roughly how many characters the run offers, directed part included.
   localparam int unsigned SYMBOL_TARGET = 1450;
   // The receiver holds off once for this many cycles after enough words went in.
   localparam int unsigned HOLD_CYCLES   = 250;
   localparam int unsigned HOLD_AFTER    = 300;
   // Generous ceiling on the run.
   localparam int unsigned CYCLE_LIMIT   = 200000;

   // Extremes of the field, both cases, full bytes, leftover bits dropped at a
   // terminator, a terminator with nothing pending, and characters that look like
   // digits or letters but sit outside the alphabet.
   localparam logic [SymbolWidth-1:0] DIRECTED_SYMBOLS [23] = '{
      8'h00, 8'hFF,
      8'h39, 8'h39, 8'h39, 8'h39, 8'h39, 8'h39, 8'h39, 8'h39,
      8'h00,
      8'h59, 8'h79, 8'h80,
      8'h61, 8'h41, 8'h33, 8'h5A, 8'h30,
      8'h6C, 8'h76, 8'h38, 8'h7F
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [SymbolWidth-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [ByteWidth-1:0]   rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;

   zb32_byte_predictor predictor;

   int unsigned symbols_sent;
   int unsigned symbols_accepted;
   int unsigned burst_left;
   bit          hold_done;

   always #5 clock = ~clock;

   zbase32_decoder_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Drops valid for the given number of cycles. The data lines carry junk meanwhile,
   // which the block must ignore.
   task automatic idle_input(input int unsigned cycles);
      for (int unsigned i = 0; i < cycles; i++) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata  <= SymbolWidth'($urandom);
      end
   endtask

   // Presents one character and holds it until the block takes the word. Valid is left
   // high afterwards so back-to-back words go out without a bubble.
   task automatic send_symbol(input logic [SymbolWidth-1:0] ch);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      do @(posedge clock); while (req_tready !== 1'b1);
      predictor.take_symbol(ch);
      symbols_accepted++;
   endtask

   // The sender works in bursts: a random run of back-to-back words, then a random gap,
   // which is sometimes left out.
   task automatic offer_symbol(input logic [SymbolWidth-1:0] ch);
      if (burst_left == 0) begin
         idle_input($urandom_range(0, 1) ? 0 : $urandom_range(1, 8));
         burst_left = $urandom_range(1, 24);
      end
      send_symbol(ch);
      burst_left--;
      symbols_sent++;
   endtask

   function automatic logic [SymbolWidth-1:0] random_alpha_symbol();
      int unsigned code;
      code = $urandom_range(0, AlphaSize - 1);
      return $urandom_range(0, 1) ? ZB_UPPER[code] : ZB_LOWER[code];
   endfunction

   function automatic logic [SymbolWidth-1:0] random_terminator();
      logic [SymbolWidth-1:0] ch;
      logic [CodeWidth-1:0]   code;
      do ch = SymbolWidth'($urandom_range(0, 255)); while (predictor.lookup(ch, code));
      return ch;
   endfunction

   // Result side: every accepted word is checked at the rising edge where it is taken.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         predictor.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // The receiver changes its stall pattern with each segment of random length: always ready,
   // coin flips, mostly stalled, or a fixed period. Once, after enough words went in, it holds
   // off for a long stretch while the sender keeps offering, so both registers fill up and
   // the input side must stall.
   initial begin
      int unsigned mode;
      int unsigned seg_len;
      int unsigned period;
      rsp_tready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (!hold_done && symbols_accepted >= HOLD_AFTER) begin
            hold_done = 1'b1;
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         mode    = $urandom_range(0, 3);
         seg_len = $urandom_range(16, 96);
         period  = $urandom_range(2, 5);
         for (int unsigned i = 0; i < seg_len; i++) begin
            @(negedge clock);
            case (mode)
               0: begin
                  rsp_tready <= 1'b1;
               end
               1: begin
                  rsp_tready <= 1'($urandom_range(0, 1));
               end
               2: begin
                  rsp_tready <= ($urandom_range(0, 7) == 0);
               end
               default: begin
                  rsp_tready <= ((i % period) != 0);
               end
            endcase
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("[%0t] timeout after %0d cycles", $time, CYCLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int unsigned pick;
      int unsigned len;
      predictor        = new();
      req_tvalid       = 1'b0;
      req_tdata        = '0;
      symbols_sent     = 0;
      symbols_accepted = 0;
      burst_left       = 0;
      hold_done        = 1'b0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_SYMBOLS[i])
         offer_symbol(DIRECTED_SYMBOLS[i]);

      // Random part. Most of it is well-formed streams of alphabet characters closed by a
      // terminator; the rest is raw noise and streams cut off by an arbitrary byte.
      while (symbols_sent < SYMBOL_TARGET) begin
         pick = $urandom_range(0, 9);
         if (pick < 8) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 64) : $urandom_range(0, 24);
            repeat (len) offer_symbol(random_alpha_symbol());
            offer_symbol(($urandom_range(0, 9) < 7) ? 8'h00 : random_terminator());
         end else if (pick == 8) begin
            repeat ($urandom_range(1, 4)) offer_symbol(SymbolWidth'($urandom_range(0, 255)));
         end else begin
            repeat ($urandom_range(1, 6)) offer_symbol(random_alpha_symbol());
            offer_symbol(SymbolWidth'($urandom_range(0, 255)));
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;

      // Let the outstanding words drain, then give the pipeline some slack so a stray extra
      // word would still be caught.
      while (predictor.expected_words.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      predictor.check_drained();

      if (predictor.mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
